/* rtl/lcs_pkg.sv */
// Shared constants, codes and inter-cell types for the longest common substring unit.
package lcs_pkg;

  localparam int MAX_LEN   = 4096;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int RUN_W     = CNT_W;
  localparam int CHAR_W    = 8;
  localparam int LEN_W     = 13;
  localparam int LEN_CAP   = (1 << LEN_W) - 1;
  localparam int REQ_W     = 2;
  localparam int NUM_CELLS = 16;
  localparam int LD_W      = $clog2(NUM_CELLS);

  localparam logic [REQ_W-1:0] REQ_FIRST  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SECOND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STREAM,
    ST_DRAIN,
    ST_DONE
  } lcs_state_t;

  // One row of the first string moving down the chain.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] chr;
    logic [RUN_W-1:0]  diag;
    logic [RUN_W-1:0]  best;
  } cell_fwd_t;

  // Column character shifted into the chain before a block of rows.
  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              col_valid;
  } cell_load_t;

endpackage

/* rtl/lcs_cell.sv */
// One column cell of the match-run chain: holds a second-string character and its run.
module lcs_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_en,
  input  lcs_pkg::cell_load_t load_in,
  output lcs_pkg::cell_load_t load_out,
  input  lcs_pkg::cell_fwd_t fwd_in,
  output lcs_pkg::cell_fwd_t fwd_out
);

  lcs_pkg::cell_load_t               held;
  logic [lcs_pkg::RUN_W-1:0]         run;
  logic [lcs_pkg::RUN_W-1:0]         run_next;
  logic [lcs_pkg::RUN_W-1:0]         best_next;
  logic                              out_valid;
  logic [lcs_pkg::CHAR_W-1:0]        out_chr;
  logic [lcs_pkg::RUN_W-1:0]         out_diag;
  logic [lcs_pkg::RUN_W-1:0]         out_best;

  always_comb begin
    if (held.col_valid && (fwd_in.chr == held.chr)) begin
      run_next = fwd_in.diag + lcs_pkg::RUN_W'(1);
    end else begin
      run_next = '0;
    end
    best_next = (run_next > fwd_in.best) ? run_next : fwd_in.best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fwd_in.valid;
    end
  end

  // Load clears the run so the block starts from an all-zero row.
  always_ff @(posedge clk) begin
    if (load_en) begin
      held <= load_in;
      run  <= '0;
    end else if (fwd_in.valid) begin
      run      <= run_next;
      out_chr  <= fwd_in.chr;
      out_diag <= run;
      out_best <= best_next;
    end
  end

  assign load_out = held;
  assign fwd_out  = '{valid: out_valid, chr: out_chr, diag: out_diag, best: out_best};

endmodule

/* rtl/longest_common_substring_length_unit.sv */
// Top level: character stores, boundary column memory, cell chain and sequencer.
// Appends (req_type 0 or 1) transfer one per cycle while the unit is idle and produce no result.
// Finish: the 16-cell chain sweeps the second string in blocks of 16 columns, one
// first-string row entering per cycle. One finish is worked on at a time.
// Reset clears both counts, the overflow flag and the result valid; stores hold garbage.
module longest_common_substring_length_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lcs_pkg::REQ_W-1:0]     req_type,
  input  logic [lcs_pkg::CHAR_W-1:0]    char_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcs_pkg::LEN_W-1:0]     common_length,
  output logic                          overflow
);

  localparam int W = lcs_pkg::NUM_CELLS;

  lcs_pkg::lcs_state_t state, state_next;

  // Character stores and the column boundary carried from one block to the next.
  logic [lcs_pkg::CHAR_W-1:0] first_text  [lcs_pkg::MAX_LEN];
  logic [lcs_pkg::CHAR_W-1:0] second_text [lcs_pkg::MAX_LEN];
  logic [lcs_pkg::RUN_W-1:0]  bnd_mem     [lcs_pkg::MAX_LEN];

  logic [lcs_pkg::CNT_W-1:0]  first_count;
  logic [lcs_pkg::CNT_W-1:0]  second_count;
  logic                       dropped_flag;

  logic [lcs_pkg::CNT_W-1:0]  col_base;
  logic [lcs_pkg::CNT_W-1:0]  col_next;
  logic [lcs_pkg::LD_W-1:0]   ld_cnt;
  logic [lcs_pkg::CNT_W-1:0]  ld_col;
  logic                       ld_pend;
  logic                       ld_colvalid;
  logic [lcs_pkg::CNT_W-1:0]  rd_row;
  logic [lcs_pkg::CNT_W-1:0]  rd_row_prev;
  logic [lcs_pkg::CNT_W-1:0]  wr_row;
  logic [lcs_pkg::CNT_W-1:0]  wr_row_prev;
  logic                       feed_valid;
  logic                       feed_zero;
  logic [lcs_pkg::RUN_W-1:0]  best;

  logic [lcs_pkg::CHAR_W-1:0] first_rd;
  logic [lcs_pkg::CHAR_W-1:0] second_rd;
  logic [lcs_pkg::RUN_W-1:0]  bnd_rd;

  // Sequencer outputs
  logic in_xfer;
  logic start_any;
  logic start_empty;
  logic ld_issue;
  logic row_issue;
  logic blk_end;
  logic finish_up;

  lcs_pkg::cell_fwd_t  fwd     [W+1];
  lcs_pkg::cell_load_t load_in [W];

  assign in_xfer     = in_valid && !in_stall;
  assign start_any   = in_xfer && (req_type == lcs_pkg::REQ_FINISH);
  assign start_empty = (first_count == '0) || (second_count == '0);
  assign col_next    = col_base + lcs_pkg::CNT_W'(W);
  assign ld_col      = col_base + lcs_pkg::CNT_W'(W - 1) - lcs_pkg::CNT_W'(ld_cnt);
  assign rd_row_prev = rd_row - lcs_pkg::CNT_W'(1);
  assign wr_row_prev = wr_row - lcs_pkg::CNT_W'(1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lcs_pkg::ST_IDLE: begin
        if (start_any) begin
          state_next = start_empty ? lcs_pkg::ST_DONE : lcs_pkg::ST_LOAD;
        end
      end
      lcs_pkg::ST_LOAD: begin
        if (ld_cnt == lcs_pkg::LD_W'(W - 1)) begin
          state_next = lcs_pkg::ST_STREAM;
        end
      end
      lcs_pkg::ST_STREAM: begin
        if (rd_row == first_count - lcs_pkg::CNT_W'(1)) begin
          state_next = lcs_pkg::ST_DRAIN;
        end
      end
      lcs_pkg::ST_DRAIN: begin
        if (wr_row == first_count) begin
          state_next = (col_next >= second_count) ? lcs_pkg::ST_DONE : lcs_pkg::ST_LOAD;
        end
      end
      lcs_pkg::ST_DONE: begin
        state_next = lcs_pkg::ST_IDLE;
      end
      default: state_next = lcs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs; hold a finish off while the previous result still waits.
  always_comb begin
    in_stall  = 1'b1;
    ld_issue  = 1'b0;
    row_issue = 1'b0;
    blk_end   = 1'b0;
    finish_up = 1'b0;
    unique case (state)
      lcs_pkg::ST_IDLE:   in_stall  = out_valid && (req_type == lcs_pkg::REQ_FINISH);
      lcs_pkg::ST_LOAD:   ld_issue  = 1'b1;
      lcs_pkg::ST_STREAM: row_issue = 1'b1;
      lcs_pkg::ST_DRAIN:  blk_end   = (wr_row == first_count);
      lcs_pkg::ST_DONE:   finish_up = 1'b1;
      default:            in_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Append path: write the byte, or drop it and flag overflow when full.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      dropped_flag <= 1'b0;
    end else if (finish_up) begin
      first_count  <= '0;
      second_count <= '0;
      dropped_flag <= 1'b0;
    end else if (in_xfer) begin
      if (req_type == lcs_pkg::REQ_FIRST) begin
        if (first_count < lcs_pkg::CNT_W'(lcs_pkg::MAX_LEN)) begin
          first_count <= first_count + lcs_pkg::CNT_W'(1);
        end else begin
          dropped_flag <= 1'b1;
        end
      end else if (req_type == lcs_pkg::REQ_SECOND) begin
        if (second_count < lcs_pkg::CNT_W'(lcs_pkg::MAX_LEN)) begin
          second_count <= second_count + lcs_pkg::CNT_W'(1);
        end else begin
          dropped_flag <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (req_type == lcs_pkg::REQ_FIRST) &&
        (first_count < lcs_pkg::CNT_W'(lcs_pkg::MAX_LEN))) begin
      first_text[first_count[lcs_pkg::ADDR_W-1:0]] <= char_code;
    end
    first_rd <= first_text[rd_row[lcs_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (req_type == lcs_pkg::REQ_SECOND) &&
        (second_count < lcs_pkg::CNT_W'(lcs_pkg::MAX_LEN))) begin
      second_text[second_count[lcs_pkg::ADDR_W-1:0]] <= char_code;
    end
    second_rd <= second_text[ld_col[lcs_pkg::ADDR_W-1:0]];
  end

  // Boundary column: the last cell's run for row r lands here while row r+1 leaves
  // the chain; the next block reads it back as the diagonal into the first cell.
  always_ff @(posedge clk) begin
    if (fwd[W].valid && (wr_row != '0)) begin
      bnd_mem[wr_row_prev[lcs_pkg::ADDR_W-1:0]] <= fwd[W].diag;
    end
    bnd_rd <= bnd_mem[rd_row_prev[lcs_pkg::ADDR_W-1:0]];
  end

  // Block and row counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      ld_pend    <= 1'b0;
      feed_valid <= 1'b0;
    end else begin
      ld_pend    <= ld_issue;
      feed_valid <= row_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (start_any) begin
      col_base <= '0;
      best     <= '0;
    end else if (blk_end) begin
      col_base <= col_next;
    end
    if (start_any || blk_end) begin
      ld_cnt <= '0;
      rd_row <= '0;
      wr_row <= '0;
    end else begin
      if (ld_issue) begin
        ld_cnt <= ld_cnt + lcs_pkg::LD_W'(1);
      end
      if (row_issue) begin
        rd_row <= rd_row + lcs_pkg::CNT_W'(1);
      end
      if (fwd[W].valid) begin
        wr_row <= wr_row + lcs_pkg::CNT_W'(1);
        if (fwd[W].best > best) begin
          best <= fwd[W].best;
        end
      end
    end
    ld_colvalid <= ld_col < second_count;
    // The first block and the first row see an all-zero diagonal.
    feed_zero   <= (rd_row == '0) || (col_base == '0);
  end

  // Chain: columns shift in from cell 0, so the highest column is read first.
  assign load_in[0] = '{chr: second_rd, col_valid: ld_colvalid};
  assign fwd[0]     = '{valid: feed_valid, chr: first_rd,
                        diag: feed_zero ? '0 : bnd_rd, best: '0};

  for (genvar k = 0; k < W; k++) begin : g_cell
    if (k < W - 1) begin : g_mid
      lcs_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load_en  (ld_pend),
        .load_in  (load_in[k]),
        .load_out (load_in[k+1]),
        .fwd_in   (fwd[k]),
        .fwd_out  (fwd[k+1])
      );
    end else begin : g_last
      lcs_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load_en  (ld_pend),
        .load_in  (load_in[k]),
        .load_out (),
        .fwd_in   (fwd[k]),
        .fwd_out  (fwd[k+1])
      );
    end
  end

  // Result register: advance on transfer, load when the sweep is done.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_up) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Saturate the length at the widest code the port carries.
  always_ff @(posedge clk) begin
    if (finish_up) begin
      if (best > lcs_pkg::RUN_W'(lcs_pkg::LEN_CAP)) begin
        common_length <= lcs_pkg::LEN_W'(lcs_pkg::LEN_CAP);
      end else begin
        common_length <= lcs_pkg::LEN_W'(best);
      end
      overflow      <= dropped_flag;
    end
  end

endmodule
